// ----- design/mrpt_pkg.sv -----
// Shared types, constants and the base table of the Miller-Rabin prime test.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mrpt_pkg;

    localparam int unsigned WORD_W            = 64;
    localparam int unsigned BASE_TABLE_SIZE   = 7;
    localparam int unsigned NUM_BASES_DEFAULT = 7;
    localparam int unsigned BASE_W            = 5;

    // Result of the front classification.
    typedef enum logic [1:0] {
        CLS_COMPOSITE,
        CLS_PRIME,
        CLS_TEST
    } cls_t;

    typedef struct packed {
        logic [WORD_W-1:0] n;
        cls_t              cls;
    } item_t;

    // Fixed witness bases 2, 3, 5, 7, 11, 13 and 17.
    function automatic logic [BASE_W-1:0] base_value(input logic [2:0] idx);
        logic [BASE_W-1:0] v;
        unique case (idx)
            3'd0:    v = 5'd2;
            3'd1:    v = 5'd3;
            3'd2:    v = 5'd5;
            3'd3:    v = 5'd7;
            3'd4:    v = 5'd11;
            3'd5:    v = 5'd13;
            3'd6:    v = 5'd17;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- design/miller_rabin_prime_test.sv -----
// Top level of the 64-bit Miller-Rabin prime test with bases 2 to 17.
// Words 0, 1, 2 and even words are settled from their class alone; an odd word
// has n-1 split into its odd part and power of two, then runs up to NUM_BASES
// bases (7 by default), each a chain of products on the bit-serial multiplier.
// The engine takes a new word only once it has passed on the last verdict.
// Reset (aresetn, synchronous) empties the queue and idles the engine.
`default_nettype none
module miller_rabin_prime_test
    import mrpt_pkg::*;
#(
    parameter int unsigned NUM_BASES = NUM_BASES_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [WORD_W-1:0] s_candidate,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_is_prime
);

    // The front stage classifies each word as it is taken, so the engine
    // settles a trivial word without the multiplier once it reaches the head
    // of the queue. Words still leave in the order they arrived.
    logic  front_valid;
    logic  front_ready;
    item_t front_item;
    logic  queue_valid;
    logic  queue_ready;
    item_t queue_item;

    mrpt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_candidate (s_candidate),
        .out_valid   (front_valid),
        .out_ready   (front_ready),
        .out_item    (front_item)
    );

    // The queue lets the front keep taking words while the engine works.
    mrpt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    // The engine owns the output register, which parts it from the sink.
    mrpt_back #(
        .NUM_BASES (NUM_BASES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (queue_valid),
        .in_ready   (queue_ready),
        .in_item    (queue_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime)
    );

endmodule
`default_nettype wire

// ----- design/mrpt_front.sv -----
// Front stage: takes candidate words and sorts out the trivial cases.
// Depends on mrpt_pkg.
`default_nettype none
module mrpt_front
    import mrpt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [WORD_W-1:0] s_candidate,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output item_t                  out_item
);

    logic  valid_reg;
    item_t item_reg;
    cls_t  cls;

    always_comb begin
        if (s_candidate[WORD_W-1:1] == '0) begin
            cls = CLS_COMPOSITE;
        end else if (s_candidate == WORD_W'(2)) begin
            cls = CLS_PRIME;
        end else if (!s_candidate[0]) begin
            cls = CLS_COMPOSITE;
        end else begin
            cls = CLS_TEST;
        end
    end

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            item_reg.n   <= s_candidate;
            item_reg.cls <= cls;
        end
    end

endmodule
`default_nettype wire

// ----- design/mrpt_fifo.sv -----
// Two-entry queue between the front stage and the test engine.
// Depends on mrpt_pkg.
`default_nettype none
module mrpt_fifo
    import mrpt_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output item_t      out_item
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ----- design/mrpt_mulmod.sv -----
// Bit-serial modular multiplier: a*b mod n, one bit of b per cycle.
// Operands must be below n. Depends on mrpt_pkg.
`default_nettype none
module mrpt_mulmod
    import mrpt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] a,
    input  wire logic [WORD_W-1:0] b,
    input  wire logic [WORD_W-1:0] n,
    output logic                   done,
    output logic [WORD_W-1:0]      res
);

    localparam int unsigned CNT_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] n_reg;
    logic [WORD_W+1:0] sum;
    logic [WORD_W+1:0] n1;
    logic [WORD_W+1:0] n2;
    logic [WORD_W-1:0] acc_next;

    // Double and add: the sum stays below 3n, so at most 2n comes off.
    always_comb begin
        n1  = {2'b00, n_reg};
        n2  = {1'b0, n_reg, 1'b0};
        sum = {1'b0, acc_reg, 1'b0} + (b_reg[WORD_W-1] ? {2'b00, a_reg} : '0);
        if (sum >= n2) begin
            acc_next = WORD_W'(sum - n2);
        end else if (sum >= n1) begin
            acc_next = WORD_W'(sum - n1);
        end else begin
            acc_next = sum[WORD_W-1:0];
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(WORD_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (start && !busy_reg) begin
            cnt_reg <= '0;
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
            n_reg   <= n;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            acc_reg <= acc_next;
            b_reg   <= {b_reg[WORD_W-2:0], 1'b0};
        end
    end

endmodule
`default_nettype wire

// ----- design/mrpt_back.sv -----
// Test engine: splits n-1, runs the witness rounds on the shared multiplier
// and holds the result bit. Depends on mrpt_pkg and mrpt_mulmod.
`default_nettype none
module mrpt_back
    import mrpt_pkg::*;
#(
    parameter int unsigned NUM_BASES = NUM_BASES_DEFAULT
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       m_valid,
    input  wire logic  m_ready,
    output logic       m_is_prime
);

    localparam int unsigned CW = $clog2(NUM_BASES + 1);
    localparam int unsigned KW = $clog2(WORD_W);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_BASE,
        ST_POW,
        ST_CHECK,
        ST_LOOP,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        DST_R,
        DST_X,
        DST_SQ
    } dest_t;

    state_t            state_reg;
    dest_t             dest_reg;
    logic [WORD_W-1:0] n_reg;
    logic [WORD_W-1:0] nm1_reg;
    logic [WORD_W-1:0] d_reg;
    logic [WORD_W-1:0] e_reg;
    logic [WORD_W-1:0] r_reg;
    logic [WORD_W-1:0] x_reg;
    logic [KW-1:0]     k_reg;
    logic [KW-1:0]     j_reg;
    logic [CW-1:0]     base_cnt_reg;
    logic              res_reg;
    logic              m_valid_reg;
    logic              m_is_prime_reg;
    logic              mul_start_reg;
    logic [WORD_W-1:0] mul_a_reg;
    logic [WORD_W-1:0] mul_b_reg;
    logic              mul_done;
    logic [WORD_W-1:0] mul_res;
    logic [BASE_W-1:0] base;

    assign base       = base_value(3'(base_cnt_reg));
    assign in_ready   = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_is_prime_reg;

    mrpt_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .n       (n_reg),
        .done    (mul_done),
        .res     (mul_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            mul_start_reg <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        n_reg        <= in_item.n;
                        d_reg        <= in_item.n - WORD_W'(1);
                        nm1_reg      <= in_item.n - WORD_W'(1);
                        k_reg        <= '0;
                        base_cnt_reg <= '0;
                        unique case (in_item.cls)
                            CLS_COMPOSITE: begin
                                res_reg   <= 1'b0;
                                state_reg <= ST_FINISH;
                            end
                            CLS_PRIME: begin
                                res_reg   <= 1'b1;
                                state_reg <= ST_FINISH;
                            end
                            default: begin
                                state_reg <= ST_SPLIT;
                            end
                        endcase
                    end
                end
                ST_SPLIT: begin
                    if (d_reg[0]) begin
                        state_reg <= ST_BASE;
                    end else begin
                        d_reg <= {1'b0, d_reg[WORD_W-1:1]};
                        k_reg <= k_reg + KW'(1);
                    end
                end
                ST_BASE: begin
                    if (base_cnt_reg == CW'(NUM_BASES)
                            || {{(WORD_W-BASE_W){1'b0}}, base} >= n_reg) begin
                        res_reg   <= 1'b1;
                        state_reg <= ST_FINISH;
                    end else begin
                        r_reg     <= WORD_W'(1);
                        x_reg     <= {{(WORD_W-BASE_W){1'b0}}, base};
                        e_reg     <= d_reg;
                        state_reg <= ST_POW;
                    end
                end
                ST_POW: begin
                    if (e_reg == '0) begin
                        state_reg <= ST_CHECK;
                    end else if (e_reg[0]) begin
                        mul_a_reg     <= r_reg;
                        mul_b_reg     <= x_reg;
                        mul_start_reg <= 1'b1;
                        dest_reg      <= DST_R;
                        state_reg     <= ST_WAIT;
                    end else begin
                        mul_a_reg     <= x_reg;
                        mul_b_reg     <= x_reg;
                        mul_start_reg <= 1'b1;
                        dest_reg      <= DST_X;
                        state_reg     <= ST_WAIT;
                    end
                end
                ST_CHECK: begin
                    j_reg <= '0;
                    if (r_reg == WORD_W'(1)) begin
                        base_cnt_reg <= base_cnt_reg + CW'(1);
                        state_reg    <= ST_BASE;
                    end else begin
                        state_reg <= ST_LOOP;
                    end
                end
                ST_LOOP: begin
                    if (j_reg == k_reg) begin
                        res_reg   <= 1'b0;
                        state_reg <= ST_FINISH;
                    end else if (r_reg == nm1_reg) begin
                        base_cnt_reg <= base_cnt_reg + CW'(1);
                        state_reg    <= ST_BASE;
                    end else begin
                        mul_a_reg     <= r_reg;
                        mul_b_reg     <= r_reg;
                        mul_start_reg <= 1'b1;
                        dest_reg      <= DST_SQ;
                        state_reg     <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (mul_done) begin
                        unique case (dest_reg)
                            DST_R: begin
                                r_reg     <= mul_res;
                                e_reg[0]  <= 1'b0;
                                state_reg <= ST_POW;
                            end
                            DST_X: begin
                                x_reg     <= mul_res;
                                e_reg     <= {1'b0, e_reg[WORD_W-1:1]};
                                state_reg <= ST_POW;
                            end
                            default: begin
                                r_reg     <= mul_res;
                                j_reg     <= j_reg + KW'(1);
                                state_reg <= ST_LOOP;
                            end
                        endcase
                    end
                end
                default: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_is_prime_reg <= res_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // The multiplier must keep every residue reduced below the modulus.
    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK || state_reg == ST_LOOP) |-> r_reg < n_reg)
        else $error("residue not reduced below the modulus");

    // A product only ever arrives while the engine is waiting for one.
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_WAIT)
        else $error("multiplier result arrived outside the wait state");

    // The odd part of n-1 is fully extracted before any base is tried.
    a_odd_part: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BASE |-> d_reg[0])
        else $error("exponent not odd when the base rounds start");

    // The squaring count never runs past the power of two in n-1.
    a_j_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOOP |-> j_reg <= k_reg)
        else $error("squaring count ran past k");

endmodule
`default_nettype wire

// ----- dv/miller_rabin_prime_test_test.sv -----
// Self-checking testbench of the 64-bit Miller-Rabin prime test.
// Depends on mrpt_pkg and miller_rabin_prime_test; the expected verdicts come from
// a predictor that uses exact 128-bit modular products.
`default_nettype none
module miller_rabin_prime_test_test;
    import mrpt_pkg::*;

    localparam int unsigned RANDOM_WORDS = 300;
    // The limit leaves room for the slowest correct word; the receiver stalls on top.
    localparam int unsigned STALL_LIMIT  = 250000;
    localparam int unsigned DRAIN_CYCLES = 100;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [WORD_W-1:0] s_candidate = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_is_prime;

    logic [WORD_W-1:0] pending_words[$];
    logic              expected_verdicts[$];
    int unsigned       words_sent = 0;
    int unsigned       verdicts_seen = 0;
    int unsigned       primes_seen = 0;
    int unsigned       mismatches = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       total_words = 0;

    always #1 aclk = ~aclk;

    miller_rabin_prime_test dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_candidate(s_candidate),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime)
    );

    // Exact a*b mod n, keeping the whole product at 128 bits.
    function automatic logic [63:0] exact_mulmod(input logic [63:0] a, input logic [63:0] b,
                                                 input logic [63:0] n);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return 64'(p % 128'(n));
    endfunction

    function automatic logic [63:0] exact_powmod(input logic [63:0] x, input logic [63:0] e,
                                                 input logic [63:0] n);
        logic [63:0] r;
        r = 64'd1;
        x = x % n;
        while (e != 0) begin
            if (e[0]) r = exact_mulmod(r, x, n);
            x = exact_mulmod(x, x, n);
            e = e >> 1;
        end
        return r;
    endfunction

    // Verdict of the strong-probable-prime test with the fixed witness bases.
    function automatic logic primality_verdict(input logic [63:0] n);
        logic [63:0] odd_part;
        logic [63:0] x;
        logic [63:0] witness;
        int          twos;
        int          j;
        if (n < 2) return 1'b0;
        if (n == 2) return 1'b1;
        if (!n[0]) return 1'b0;
        odd_part = n - 1;
        twos = 0;
        while (!odd_part[0]) begin
            odd_part = odd_part >> 1;
            twos++;
        end
        for (int i = 0; i < BASE_TABLE_SIZE; i++) begin
            witness = (i == 0) ? 2 : (i == 1) ? 3 : (i == 2) ? 5 : (i == 3) ? 7 :
                      (i == 4) ? 11 : (i == 5) ? 13 : 17;
            if (witness >= n) return 1'b1;
            x = exact_powmod(witness, odd_part, n);
            if (x != 1) begin
                for (j = 0; j < twos; j++) begin
                    if (x == n - 1) break;
                    x = exact_mulmod(x, x, n);
                end
                if (j == twos) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Idle odds in percent: the sender leads, then the receiver, then neither.
    function automatic int unsigned sender_idle_pct();
        if (words_sent < total_words / 3) return 22;
        if (words_sent < 2 * total_words / 3) return 49;
        return 0;
    endfunction

    function automatic int unsigned receiver_idle_pct();
        if (words_sent < total_words / 3) return 49;
        if (words_sent < 2 * total_words / 3) return 22;
        return 0;
    endfunction

    // Driver: a word is taken at an edge where valid and ready are both high,
    // and its verdict is queued at once. A new word only follows an accepted one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_verdicts.push_back(primality_verdict(s_candidate));
                words_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct()) begin
                    s_valid     <= 1'b1;
                    s_candidate <= pending_words.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every accepted verdict is held against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                verdicts_seen++;
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected verdict %0b with no word outstanding",
                                 m_is_prime);
                end else begin
                    if (expected_verdicts[0]) primes_seen++;
                    if (m_is_prime !== expected_verdicts[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("verdict %0d: expected %0b, got %0b", verdicts_seen,
                                     expected_verdicts[0], m_is_prime);
                    end
                    void'(expected_verdicts.pop_front());
                end
            end
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // Watchdog: too long without any handshake on either side ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [63:0] word;
        int unsigned pick;
        // Directed words: the trivial cases, bases at or above the word, small
        // composites, strong pseudoprimes to the early bases and the widest words.
        pending_words = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd7, 64'd11,
                          64'd13, 64'd17, 64'd9, 64'd15, 64'd19, 64'd25, 64'd2047,
                          64'd1373653, 64'd25326001, 64'd3215031751, 64'd341550071728321,
                          64'd2305843009213693951, 64'd18446744073709551557,
                          64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                          64'h8000_0000_0000_0001};
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                word = {$urandom, $urandom};
            else if (pick < 45)
                word = 64'($urandom_range(0, 255));
            else if (pick < 85)
                word = 64'($urandom_range(0, 4095)) | 64'd1;
            else
                word = 64'($urandom_range(1, 65535) | 1) * 64'($urandom_range(3, 65535) | 1);
            pending_words.push_back(word);
        end
        total_words = pending_words.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_words.size() == 0 && !s_valid && expected_verdicts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d words tested, %0d verdicts returned, %0d of them prime",
                 words_sent, verdicts_seen, primes_seen);
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
